>>> hdl/ccl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Connected component labeling package
// Shared types, codes and constants for the labeling block.
// ----------------------------------------------------------------------------
package ccl_pkg;

    localparam int DEF_MAX_ROWS = 256;
    localparam int DEF_MAX_COLS = 256;

    localparam int LABEL_W   = 15;
    localparam int LABEL_MAX = 32767;

    // Item kinds carried in tuser.
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_RUN   = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_USED_ROWS = 2'd1;
    localparam logic [1:0] CFG_USED_COLS = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_WAIT,
        S_INIT,
        S_SC_RD,
        S_SC_CHK,
        S_NB_SEL,
        S_NB_CHK,
        S_F_STEP,
        S_F_HALF,
        S_LB_RD,
        S_LB_CHK,
        S_LB_WAIT,
        S_DONE,
        S_OUT
    } t_state;

    // Which caller a root search returns to.
    typedef enum logic [1:0] {
        RET_A,
        RET_B,
        RET_L
    } t_find_ret;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] row_index;
        logic [7:0] col_index;
        logic [7:0] pixel;
    } t_item;

    typedef struct packed {
        logic [7:0] threshold;
        logic [8:0] used_rows;
        logic [8:0] used_cols;
    } t_cfg;

    typedef struct packed {
        logic               valid;
        logic [LABEL_W-1:0] label;
        logic [LABEL_W-1:0] object_count;
    } t_res;

endpackage

>>> hdl/ccl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ccl_ram #(
    parameter int AW = 16,
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [(1 << AW)];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> hdl/ccl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Labeling sequencer
// Runs pixel writes, label reads and the union-find labeling pass over the
// image, parent and label memories, one memory access per port per cycle.
// ----------------------------------------------------------------------------
module ccl_ctrl #(
    parameter int MAX_ROWS = ccl_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = ccl_pkg::DEF_MAX_COLS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_item_valid,
    input  ccl_pkg::t_item i_item,
    input  ccl_pkg::t_cfg  i_cfg,
    input  logic           i_res_take,
    output logic           o_ready,
    output ccl_pkg::t_res  o_res
);

    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int AW = RW + CW;
    localparam int LW = ccl_pkg::LABEL_W;

    ccl_pkg::t_state    r_state, n_state;
    ccl_pkg::t_find_ret r_ret, n_ret;
    logic [RW-1:0]      r_r, n_r;
    logic [CW-1:0]      r_c, n_c;
    logic [1:0]         r_nb, n_nb;
    logic [AW-1:0]      r_x, n_x;
    logic [AW-1:0]      r_ra, n_ra;
    logic [AW-1:0]      r_q, n_q;
    logic [LW-1:0]      r_count, n_count;
    logic [LW-1:0]      r_found, n_found;
    logic [LW-1:0]      r_lab, n_lab;
    logic               r_rd_ok, n_rd_ok;

    // Memory ports.
    logic          img_we;
    logic [AW-1:0] img_waddr, img_raddr;
    logic [7:0]    img_wdata, img_rdata;
    logic          par_we;
    logic [AW-1:0] par_waddr, par_wdata, par_raddr, par_rdata;
    logic          lbl_we;
    logic [AW-1:0] lbl_waddr, lbl_raddr;
    logic [LW-1:0] lbl_wdata, lbl_rdata;

    // Shared decode.
    logic [RW:0]   lim_r, r_inc;
    logic [CW:0]   lim_c, c_inc, nb_c;
    logic [RW:0]   nb_r;
    logic          nb_ok, nb_last;
    logic [AW-1:0] p, nb_addr, in_addr;
    logic          img_fg, find_done, area_empty, area_eol, area_last;
    logic          full_eol, full_last, in_area, in_range;
    logic [LW-1:0] count_sat;
    ccl_pkg::t_state nb_next, lb_next;

    ccl_ram #(.AW(AW), .DW(8)) u_img (
        .i_clk(i_clk), .i_we(img_we), .i_waddr(img_waddr), .i_wdata(img_wdata),
        .i_raddr(img_raddr), .o_rdata(img_rdata)
    );

    ccl_ram #(.AW(AW), .DW(AW)) u_par (
        .i_clk(i_clk), .i_we(par_we), .i_waddr(par_waddr), .i_wdata(par_wdata),
        .i_raddr(par_raddr), .o_rdata(par_rdata)
    );

    ccl_ram #(.AW(AW), .DW(LW)) u_lbl (
        .i_clk(i_clk), .i_we(lbl_we), .i_waddr(lbl_waddr), .i_wdata(lbl_wdata),
        .i_raddr(lbl_raddr), .o_rdata(lbl_rdata)
    );

    always_comb begin
        lim_r = (32'(i_cfg.used_rows) > MAX_ROWS) ? (RW+1)'(MAX_ROWS)
                                                  : (RW+1)'(i_cfg.used_rows);
        lim_c = (32'(i_cfg.used_cols) > MAX_COLS) ? (CW+1)'(MAX_COLS)
                                                  : (CW+1)'(i_cfg.used_cols);
        p          = {r_r, r_c};
        r_inc      = {1'b0, r_r} + 1'b1;
        c_inc      = {1'b0, r_c} + 1'b1;
        area_empty = (lim_r == '0) || (lim_c == '0);
        area_eol   = (c_inc == lim_c);
        area_last  = area_eol && (r_inc == lim_r);
        full_eol   = (c_inc == (CW+1)'(MAX_COLS));
        full_last  = full_eol && (r_inc == (RW+1)'(MAX_ROWS));
        in_area    = ({1'b0, r_r} < lim_r) && ({1'b0, r_c} < lim_c);
        img_fg     = (img_rdata >= i_cfg.threshold);
        find_done  = (par_rdata == r_x);
        count_sat  = (r_count < LW'(ccl_pkg::LABEL_MAX)) ? r_count + 1'b1 : r_count;
        in_range   = (32'(i_item.row_index) < MAX_ROWS) &&
                     (32'(i_item.col_index) < MAX_COLS);
        in_addr    = {RW'(i_item.row_index), CW'(i_item.col_index)};

        // Neighbors in order: right, down-left, down, down-right.
        nb_r = (r_nb == 2'd0) ? {1'b0, r_r} : r_inc;
        case (r_nb)
            2'd0:    nb_c = c_inc;
            2'd1:    nb_c = {1'b0, r_c} - 1'b1;
            2'd2:    nb_c = {1'b0, r_c};
            default: nb_c = c_inc;
        endcase
        nb_ok   = (nb_r < lim_r) && (nb_c < lim_c) && !((r_nb == 2'd1) && (r_c == '0));
        nb_addr = {nb_r[RW-1:0], nb_c[CW-1:0]};
        nb_last = (r_nb == 2'd3);
        nb_next = !nb_last ? ccl_pkg::S_NB_SEL
                           : (area_last ? ccl_pkg::S_LB_RD : ccl_pkg::S_SC_RD);
        lb_next = full_last ? ccl_pkg::S_DONE : ccl_pkg::S_LB_RD;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ccl_pkg::S_IDLE: begin
                if (i_item_valid) begin
                    if (i_item.kind == ccl_pkg::KIND_RUN) begin
                        n_state = area_empty ? ccl_pkg::S_LB_RD : ccl_pkg::S_INIT;
                    end else if (i_item.kind == ccl_pkg::KIND_READ) begin
                        n_state = ccl_pkg::S_RD_WAIT;
                    end
                end
            end
            ccl_pkg::S_RD_WAIT: n_state = ccl_pkg::S_OUT;
            ccl_pkg::S_INIT:    n_state = area_last ? ccl_pkg::S_SC_RD : ccl_pkg::S_INIT;
            ccl_pkg::S_SC_RD:   n_state = ccl_pkg::S_SC_CHK;
            ccl_pkg::S_SC_CHK: begin
                if (img_fg) begin
                    n_state = ccl_pkg::S_NB_SEL;
                end else begin
                    n_state = area_last ? ccl_pkg::S_LB_RD : ccl_pkg::S_SC_RD;
                end
            end
            ccl_pkg::S_NB_SEL:  n_state = nb_ok ? ccl_pkg::S_NB_CHK : nb_next;
            ccl_pkg::S_NB_CHK:  n_state = img_fg ? ccl_pkg::S_F_STEP : nb_next;
            ccl_pkg::S_F_STEP: begin
                if (!find_done) begin
                    n_state = ccl_pkg::S_F_HALF;
                end else begin
                    case (r_ret)
                        ccl_pkg::RET_A: n_state = ccl_pkg::S_F_STEP;
                        ccl_pkg::RET_B: n_state = nb_next;
                        default:        n_state = (r_x == p) ? lb_next : ccl_pkg::S_LB_WAIT;
                    endcase
                end
            end
            ccl_pkg::S_F_HALF:  n_state = ccl_pkg::S_F_STEP;
            ccl_pkg::S_LB_RD:   n_state = ccl_pkg::S_LB_CHK;
            ccl_pkg::S_LB_CHK:  n_state = (img_fg && in_area) ? ccl_pkg::S_F_STEP : lb_next;
            ccl_pkg::S_LB_WAIT: n_state = lb_next;
            ccl_pkg::S_DONE:    n_state = ccl_pkg::S_OUT;
            ccl_pkg::S_OUT:     n_state = i_res_take ? ccl_pkg::S_IDLE : ccl_pkg::S_OUT;
            default:            n_state = ccl_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory controls.
    always_comb begin
        logic do_nb_adv;
        logic do_area_adv;
        logic do_full_adv;
        do_nb_adv   = 1'b0;
        do_area_adv = 1'b0;
        do_full_adv = 1'b0;
        n_ret   = r_ret;
        n_r     = r_r;
        n_c     = r_c;
        n_nb    = r_nb;
        n_x     = r_x;
        n_ra    = r_ra;
        n_q     = r_q;
        n_count = r_count;
        n_found = r_found;
        n_lab   = r_lab;
        n_rd_ok = r_rd_ok;
        img_we    = 1'b0;
        img_waddr = in_addr;
        img_wdata = i_item.pixel;
        img_raddr = p;
        par_we    = 1'b0;
        par_waddr = p;
        par_wdata = p;
        par_raddr = p;
        lbl_we    = 1'b0;
        lbl_waddr = p;
        lbl_wdata = '0;
        lbl_raddr = in_addr;

        case (r_state)
            ccl_pkg::S_IDLE: begin
                if (i_item_valid) begin
                    if (i_item.kind == ccl_pkg::KIND_WRITE) begin
                        img_we = in_range;
                    end else if (i_item.kind == ccl_pkg::KIND_RUN) begin
                        n_r     = '0;
                        n_c     = '0;
                        n_count = '0;
                    end else if (i_item.kind == ccl_pkg::KIND_READ) begin
                        n_rd_ok = in_range;
                    end
                end
            end
            ccl_pkg::S_RD_WAIT: n_lab = r_rd_ok ? lbl_rdata : '0;
            ccl_pkg::S_INIT: begin
                par_we      = 1'b1;
                do_area_adv = 1'b1;
            end
            ccl_pkg::S_SC_CHK: begin
                if (img_fg) begin
                    n_nb = 2'd0;
                end else begin
                    do_area_adv = 1'b1;
                end
            end
            ccl_pkg::S_NB_SEL: begin
                if (nb_ok) begin
                    img_raddr = nb_addr;
                    n_q       = nb_addr;
                end else begin
                    do_nb_adv = 1'b1;
                end
            end
            ccl_pkg::S_NB_CHK: begin
                if (img_fg) begin
                    n_x   = p;
                    n_ret = ccl_pkg::RET_A;
                end else begin
                    do_nb_adv = 1'b1;
                end
            end
            ccl_pkg::S_F_STEP: begin
                if (!find_done) begin
                    par_raddr = par_rdata;
                end else begin
                    case (r_ret)
                        ccl_pkg::RET_A: begin
                            n_ra      = r_x;
                            n_x       = r_q;
                            par_raddr = r_q;
                            n_ret     = ccl_pkg::RET_B;
                        end
                        ccl_pkg::RET_B: begin
                            // Hang the larger root under the smaller one.
                            if (r_ra < r_x) begin
                                par_we    = 1'b1;
                                par_waddr = r_x;
                                par_wdata = r_ra;
                            end else if (r_x < r_ra) begin
                                par_we    = 1'b1;
                                par_waddr = r_ra;
                                par_wdata = r_x;
                            end
                            do_nb_adv = 1'b1;
                        end
                        default: begin
                            // The root is the component's first pixel, so it
                            // opens a new label; otherwise copy the root's label.
                            if (r_x == p) begin
                                n_count     = count_sat;
                                lbl_we      = 1'b1;
                                lbl_wdata   = count_sat;
                                do_full_adv = 1'b1;
                            end else begin
                                lbl_raddr = r_x;
                            end
                        end
                    endcase
                end
            end
            ccl_pkg::S_F_HALF: begin
                par_we    = 1'b1;
                par_waddr = r_x;
                par_wdata = par_rdata;
                n_x       = par_rdata;
                par_raddr = par_rdata;
            end
            ccl_pkg::S_LB_CHK: begin
                if (img_fg && in_area) begin
                    n_x   = p;
                    n_ret = ccl_pkg::RET_L;
                end else begin
                    lbl_we      = 1'b1;
                    do_full_adv = 1'b1;
                end
            end
            ccl_pkg::S_LB_WAIT: begin
                lbl_we      = 1'b1;
                lbl_wdata   = lbl_rdata;
                do_full_adv = 1'b1;
            end
            ccl_pkg::S_DONE: begin
                n_found = r_count;
                n_lab   = '0;
            end
            default: begin
            end
        endcase

        if (do_nb_adv) begin
            if (!nb_last) begin
                n_nb = r_nb + 1'b1;
            end else begin
                do_area_adv = 1'b1;
            end
        end
        if (do_area_adv) begin
            n_c = area_eol ? '0 : c_inc[CW-1:0];
            n_r = area_last ? '0 : (area_eol ? r_inc[RW-1:0] : r_r);
        end
        if (do_full_adv) begin
            n_c = full_eol ? '0 : c_inc[CW-1:0];
            n_r = full_eol ? r_inc[RW-1:0] : r_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ccl_pkg::S_IDLE;
            r_found <= '0;
        end else begin
            r_state <= n_state;
            r_found <= n_found;
        end
        r_ret   <= n_ret;
        r_r     <= n_r;
        r_c     <= n_c;
        r_nb    <= n_nb;
        r_x     <= n_x;
        r_ra    <= n_ra;
        r_q     <= n_q;
        r_count <= n_count;
        r_lab   <= n_lab;
        r_rd_ok <= n_rd_ok;
    end

    assign o_ready            = (r_state == ccl_pkg::S_IDLE);
    assign o_res.valid        = (r_state == ccl_pkg::S_OUT);
    assign o_res.label        = r_lab;
    assign o_res.object_count = r_found;

endmodule

>>> hdl/connected_component_labeling_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Connected component labeling, 8-connected
// Holds a grey image, labels its foreground regions and answers label reads.
// ----------------------------------------------------------------------------
// Items enter on the s_axis channel, the kind in tuser. A write transfer stores
// one pixel and gives no result; it leaves the sequencer idle. A read transfer
// returns the pixel's label and the current object count; it passes the label
// memory's registered read, the sequencer's result register and the output
// register, and m_axis_tvalid rises when the input is ready again. A run
// transfer labels the used area and returns the object count. It sets up the
// parent table over the used pixels, then scans them; for a foreground pixel it
// looks at its neighbors and, for a foreground neighbor, chases both roots to
// join the regions. Last it writes labels over the whole MAX_ROWS x MAX_COLS
// image, finding the root of each foreground pixel. The run is paced by the
// single read port of the parent memory, which the root search walks one hop at a time.
// s_axis_tready is high only while the sequencer is idle. Results sit in an
// output register; when the receiver stalls, the sequencer holds its result
// until the register frees and takes no new transfer meanwhile.
// Reset empties the output register, clears the object count and loads the
// threshold with 128 and both sizes with 256; memories keep their contents.
// Configuration writes are taken at any edge with i_cfg_we high, outside reset.
// ----------------------------------------------------------------------------
module connected_component_labeling_top #(
    parameter int MAX_ROWS = ccl_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = ccl_pkg::DEF_MAX_COLS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // row_index, col_index, pixel
    input  logic [1:0]  s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // label, object_count, zero pad
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [8:0]  i_cfg_data
);

    ccl_pkg::t_item item;
    ccl_pkg::t_cfg  cfg;
    ccl_pkg::t_res  res;
    logic           ready;
    logic           take;
    logic           s_xfer;

    logic [7:0]  r_threshold;
    logic [8:0]  r_used_rows;
    logic [8:0]  r_used_cols;
    logic        r_m_valid, n_m_valid;
    logic [31:0] r_m_data;

    assign item.kind      = s_axis_tuser;
    assign item.row_index = s_axis_tdata[7:0];
    assign item.col_index = s_axis_tdata[15:8];
    assign item.pixel     = s_axis_tdata[23:16];

    assign cfg.threshold = r_threshold;
    assign cfg.used_rows = r_used_rows;
    assign cfg.used_cols = r_used_cols;

    assign s_xfer = s_axis_tvalid && ready;

    ccl_ctrl #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (s_xfer),
        .i_item       (item),
        .i_cfg        (cfg),
        .i_res_take   (take),
        .o_ready      (ready),
        .o_res        (res)
    );

    // The output register takes a result whenever it is empty or being drained.
    assign take = res.valid && (!r_m_valid || m_axis_tready);

    always_comb begin
        n_m_valid = r_m_valid;
        if (take) begin
            n_m_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= 8'd128;
            r_used_rows <= 9'd256;
            r_used_cols <= 9'd256;
            r_m_valid   <= 1'b0;
        end else begin
            r_m_valid <= n_m_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ccl_pkg::CFG_THRESHOLD: r_threshold <= i_cfg_data[7:0];
                    ccl_pkg::CFG_USED_ROWS: r_used_rows <= i_cfg_data;
                    ccl_pkg::CFG_USED_COLS: r_used_cols <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
        if (take) begin
            r_m_data <= {2'b00, res.object_count, res.label};
        end
    end

    assign s_axis_tready = ready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // A run or a read keeps the sequencer busy in the following cycle.
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == ccl_pkg::KIND_RUN)
        |=> !s_axis_tready)
        else $error("input taken right after a run transfer");

    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == ccl_pkg::KIND_READ)
        |=> !s_axis_tready)
        else $error("input taken right after a read transfer");

    // A pending result from the sequencer means it is not idle.
    a_res_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.valid |-> !s_axis_tready)
        else $error("sequencer ready while holding a result");

    // A write leaves the sequencer idle.
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == ccl_pkg::KIND_WRITE)
        |=> s_axis_tready)
        else $error("pixel write left the idle state");

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Connected component labeling testbench
// Drives pixel writes, labeling runs and label reads into the block through
// its stream ports, reprograms threshold and area between phases, and checks
// every result against a union-find predictor kept inside the bench.
// ----------------------------------------------------------------------------
module tb;

    localparam int ROWS  = 256;
    localparam int COLS  = 256;
    localparam int CELLS = ROWS * COLS;

    // Generous bound: each run walks the whole image, and there are eleven runs
    // plus stalls and gaps.
    localparam longint CYCLE_LIMIT = 30000000;

    // Kind 3 carries no meaning; the block drops it.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Cycles allowed after the last expected result before an idle action.
    localparam int SETTLE = 12;

    typedef struct {
        logic [ccl_pkg::LABEL_W-1:0] label;
        logic [ccl_pkg::LABEL_W-1:0] count;
    } t_answer;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [8:0]  i_cfg_data;

    connected_component_labeling_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: a copy of the image, the label map of the latest
    // run, the object count and the programmed registers.
    // ------------------------------------------------------------------
    logic [7:0]                  img_copy   [CELLS];
    bit                          img_known  [CELLS];
    logic [ccl_pkg::LABEL_W-1:0] label_copy [CELLS];
    int                          parent     [CELLS];
    int                          root_num   [CELLS];
    logic [ccl_pkg::LABEL_W-1:0] objects_seen;
    logic [7:0]                  cur_thr;
    logic [8:0]                  cur_rows;
    logic [8:0]                  cur_cols;

    ccl_pkg::t_item pend_items[$];
    t_answer        answers_due[$];

    int     errors;
    longint cycles;
    bit     in_taken;
    bit     hold_done;
    int     hold_left;
    int     burst_left;
    int     gap_left;
    int     stall_mode;
    int     stall_phase;

    function automatic int eff_rows();
        return (cur_rows > ROWS) ? ROWS : int'(cur_rows);
    endfunction

    function automatic int eff_cols();
        return (cur_cols > COLS) ? COLS : int'(cur_cols);
    endfunction

    function automatic bit is_object(int r, int c);
        if (r < 0 || c < 0 || r >= eff_rows() || c >= eff_cols())
            return 0;
        return img_copy[r * COLS + c] >= cur_thr;
    endfunction

    // Root search with path halving.
    function automatic int root_of(int p);
        while (parent[p] != p) begin
            parent[p] = parent[parent[p]];
            p = parent[p];
        end
        return p;
    endfunction

    function automatic void merge(int a, int b);
        int ra;
        int rb;
        ra = root_of(a);
        rb = root_of(b);
        if (ra < rb)
            parent[rb] = ra;
        else if (rb < ra)
            parent[ra] = rb;
    endfunction

    // Labels the used area. The partition does not depend on the scan used
    // to build it, and numbering follows the raster order of each region's
    // first pixel, so the labels are fixed by the image alone.
    function automatic void label_image();
        int nr;
        int nc;
        int p;
        int rt;
        int n;
        nr = eff_rows();
        nc = eff_cols();
        n  = 0;
        for (int i = 0; i < CELLS; i++) begin
            parent[i]     = i;
            root_num[i]   = 0;
            label_copy[i] = '0;
        end
        for (int r = 0; r < nr; r++) begin
            for (int c = 0; c < nc; c++) begin
                if (!is_object(r, c))
                    continue;
                p = r * COLS + c;
                // Link to the already visited neighbors: left and the row above.
                if (is_object(r, c - 1))
                    merge(p, p - 1);
                if (is_object(r - 1, c - 1))
                    merge(p, p - COLS - 1);
                if (is_object(r - 1, c))
                    merge(p, p - COLS);
                if (is_object(r - 1, c + 1))
                    merge(p, p - COLS + 1);
            end
        end
        for (int r = 0; r < nr; r++) begin
            for (int c = 0; c < nc; c++) begin
                if (!is_object(r, c))
                    continue;
                p  = r * COLS + c;
                rt = root_of(p);
                if (root_num[rt] == 0) begin
                    if (n < ccl_pkg::LABEL_MAX)
                        n++;
                    root_num[rt] = n;
                end
                label_copy[p] = ccl_pkg::LABEL_W'(root_num[rt]);
            end
        end
        objects_seen = ccl_pkg::LABEL_W'(n);
    endfunction

    // Applies one accepted item and queues the result it should produce.
    function automatic void predict_item(ccl_pkg::t_item it);
        t_answer a;
        case (it.kind)
            ccl_pkg::KIND_WRITE: begin
                img_copy[{it.row_index, it.col_index}] = it.pixel;
            end
            ccl_pkg::KIND_RUN: begin
                label_image();
                a.label = '0;
                a.count = objects_seen;
                answers_due.push_back(a);
            end
            ccl_pkg::KIND_READ: begin
                a.label = label_copy[{it.row_index, it.col_index}];
                a.count = objects_seen;
                answers_due.push_back(a);
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Clock, cycle limit
    // ------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge. A result is checked
    // before the input transfer of the same edge is predicted, although a
    // result can never stem from an item taken at that very edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_answer        a;
        ccl_pkg::t_item it;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (answers_due.size() == 0) begin
                $display("%0t: unexpected result label %0d count %0d", $time,
                         m_axis_tdata[14:0], m_axis_tdata[29:15]);
                errors++;
            end else begin
                a = answers_due.pop_front();
                if (m_axis_tdata[14:0] !== a.label) begin
                    $display("%0t: label expected %0d actual %0d", $time,
                             a.label, m_axis_tdata[14:0]);
                    errors++;
                end
                if (m_axis_tdata[29:15] !== a.count) begin
                    $display("%0t: object count expected %0d actual %0d", $time,
                             a.count, m_axis_tdata[29:15]);
                    errors++;
                end
            end
        end
        in_taken = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (in_taken) begin
            it.kind      = s_axis_tuser;
            it.row_index = s_axis_tdata[7:0];
            it.col_index = s_axis_tdata[15:8];
            it.pixel     = s_axis_tdata[23:16];
            predict_item(it);
        end
    end

    // The long receiver hold-off starts at the first read transfer. Reads
    // keep coming while the output register is full, so the block backs up
    // and drops s_axis_tready.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && i_rst_n && s_axis_tvalid && s_axis_tready &&
                     s_axis_tuser == ccl_pkg::KIND_READ) begin
            hold_left <= 400;
            hold_done <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Driver: bursts of transfers from the pending queue with random gaps.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        ccl_pkg::t_item it;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !in_taken) begin
            // Hold the offered item until it is taken.
        end else if (gap_left > 0) begin
            gap_left--;
            s_axis_tvalid <= 1'b0;
        end else if (pend_items.size() > 0) begin
            it = pend_items.pop_front();
            s_axis_tvalid <= 1'b1;
            s_axis_tuser  <= it.kind;
            s_axis_tdata  <= {it.pixel, it.col_index, it.row_index};
            if (burst_left > 0)
                burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver: each time the stall phase counter wraps, the pattern is picked anew
    // among no stall, light stall and heavy stall, and the hold-off overrides it.
    always @(negedge i_clk) begin
        stall_phase++;
        if (stall_phase >= 64) begin
            stall_phase = 0;
            stall_mode  = $urandom_range(0, 2);
        end
        if (hold_left > 0)
            m_axis_tready <= 1'b0;
        else if (stall_mode == 0)
            m_axis_tready <= 1'b1;
        else if (stall_mode == 1)
            m_axis_tready <= ($urandom_range(0, 3) != 0);
        else
            m_axis_tready <= ($urandom_range(0, 3) == 0);
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic wait_idle();
        do @(posedge i_clk);
        while (pend_items.size() != 0 || s_axis_tvalid || answers_due.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [8:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        case (idx)
            ccl_pkg::CFG_THRESHOLD: cur_thr  = value[7:0];
            ccl_pkg::CFG_USED_ROWS: cur_rows = value;
            ccl_pkg::CFG_USED_COLS: cur_cols = value;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_item(logic [1:0] kind, int r, int c, int px);
        ccl_pkg::t_item it;
        it.kind      = kind;
        it.row_index = r[7:0];
        it.col_index = c[7:0];
        it.pixel     = px[7:0];
        if (kind == ccl_pkg::KIND_WRITE)
            img_known[r * COLS + c] = 1;
        pend_items.push_back(it);
    endtask

    // Grey values that land on either side of the threshold, its edges
    // included, so that regions form and break.
    function automatic int grey_value();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 255;
            2:       return cur_thr;
            3:       return (cur_thr == 0) ? 0 : cur_thr - 1;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    task automatic random_items(int n);
        int nr;
        int nc;
        int pick;
        nr = eff_rows();
        nc = eff_cols();
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 19);
            if (pick < 11 && nr > 0 && nc > 0)
                push_item(ccl_pkg::KIND_WRITE, $urandom_range(0, nr - 1),
                          $urandom_range(0, nc - 1), grey_value());
            else if (pick < 12)
                push_item(KIND_UNUSED, $urandom_range(0, 255),
                          $urandom_range(0, 255), $urandom_range(0, 255));
            else if (pick < 16 && nr > 0 && nc > 0)
                push_item(ccl_pkg::KIND_READ, $urandom_range(0, nr - 1),
                          $urandom_range(0, nc - 1), $urandom_range(0, 255));
            else
                push_item(ccl_pkg::KIND_READ, $urandom_range(0, 255),
                          $urandom_range(0, 255), $urandom_range(0, 255));
        end
    endtask

    // One phase: program the registers while idle, fill every pixel of the
    // area that was never written, then mixed traffic around a run.
    task automatic phase(int rows, int cols, int thr, int n_mixed);
        wait_idle();
        write_reg(ccl_pkg::CFG_THRESHOLD, thr[8:0]);
        write_reg(ccl_pkg::CFG_USED_ROWS, rows[8:0]);
        write_reg(ccl_pkg::CFG_USED_COLS, cols[8:0]);
        for (int r = 0; r < eff_rows(); r++)
            for (int c = 0; c < eff_cols(); c++)
                if (!img_known[r * COLS + c])
                    push_item(ccl_pkg::KIND_WRITE, r, c, grey_value());
        random_items(n_mixed / 2);
        push_item(ccl_pkg::KIND_RUN, $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 255));
        random_items(n_mixed - n_mixed / 2);
    endtask

    initial begin
        errors        = 0;
        cycles        = 0;
        in_taken      = 0;
        hold_done     = 0;
        hold_left     = 0;
        burst_left    = 0;
        gap_left      = 0;
        stall_mode    = 0;
        stall_phase   = 0;
        objects_seen  = '0;
        cur_thr       = 8'd128;
        cur_rows      = 9'd256;
        cur_cols      = 9'd256;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ccl_pkg::KIND_WRITE;
        m_axis_tready = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = ccl_pkg::CFG_THRESHOLD;
        i_cfg_data    = '0;
        for (int i = 0; i < CELLS; i++) begin
            img_copy[i]   = '0;
            img_known[i]  = 0;
            label_copy[i] = '0;
        end
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: a 3x3 area at the reset threshold with pixels on both
        // sides of it and three diagonal-only touches joining all foreground pixels.
        write_reg(ccl_pkg::CFG_THRESHOLD, 9'd128);
        write_reg(ccl_pkg::CFG_USED_ROWS, 9'd3);
        write_reg(ccl_pkg::CFG_USED_COLS, 9'd3);
        push_item(ccl_pkg::KIND_WRITE, 0, 0, 255);
        push_item(ccl_pkg::KIND_WRITE, 0, 1, 127);
        push_item(ccl_pkg::KIND_WRITE, 0, 2, 128);
        push_item(ccl_pkg::KIND_WRITE, 1, 0, 0);
        push_item(ccl_pkg::KIND_WRITE, 1, 1, 200);
        push_item(ccl_pkg::KIND_WRITE, 1, 2, 0);
        push_item(ccl_pkg::KIND_WRITE, 2, 0, 127);
        push_item(ccl_pkg::KIND_WRITE, 2, 1, 0);
        push_item(ccl_pkg::KIND_WRITE, 2, 2, 129);
        push_item(KIND_UNUSED, 255, 255, 255);
        push_item(ccl_pkg::KIND_RUN, 0, 0, 0);
        // Reads in and outside the area, the far corner among them.
        push_item(ccl_pkg::KIND_READ, 0, 0, 0);
        push_item(ccl_pkg::KIND_READ, 2, 2, 0);
        push_item(ccl_pkg::KIND_READ, 0, 1, 0);
        push_item(ccl_pkg::KIND_READ, 255, 255, 255);
        push_item(ccl_pkg::KIND_READ, 0, 255, 0);
        push_item(ccl_pkg::KIND_READ, 255, 0, 0);
        // A write after the run leaves labels alone until the next run.
        push_item(ccl_pkg::KIND_WRITE, 0, 1, 255);
        push_item(ccl_pkg::KIND_READ, 0, 1, 0);
        push_item(ccl_pkg::KIND_RUN, 0, 0, 0);
        push_item(ccl_pkg::KIND_READ, 0, 1, 0);
        push_item(ccl_pkg::KIND_READ, 1, 1, 0);

        // One full-width row, everything foreground at threshold zero.
        phase(1, 256, 0, 30);
        // Column width beyond the image saturates; row 0 is already written.
        phase(1, 511, $urandom_range(1, 254), 20);
        // One full-height column, only white pixels count at threshold 255.
        phase(256, 1, 255, 30);
        // An empty area: the scan is skipped, every label is cleared and the count is zero.
        phase(0, 5, 128, 12);
        for (int k = 0; k < 5; k++)
            phase($urandom_range(1, 12), $urandom_range(1, 12),
                  $urandom_range(0, 255), 30);

        wait_idle();
        repeat (50) @(posedge i_clk);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
